/* sv/sawl_pkg.sv */
// Shared types, sizes and status codes of the slot allocator with wait queue.
`default_nettype none

package sawl_pkg;

    localparam int SLOTS    = 16;
    localparam int WAITERS  = 16;

    localparam int ID_W     = 8;
    localparam int STATUS_W = 3;
    localparam int SLOTF_W  = 4;
    localparam int QLEN_W   = 5;

    localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int QIDX_W   = (WAITERS > 1) ? $clog2(WAITERS) : 1;
    localparam int CNT_W    = $clog2(WAITERS + 1);
    localparam int SCAN_W   = ($clog2(SLOTS + 1) > CNT_W) ? $clog2(SLOTS + 1) : CNT_W;

    localparam logic CMD_REQUEST = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_GRANTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_QUEUED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_WAITING  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RELEASE  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_HANDOFF  = 3'b001;
    localparam logic [STATUS_W-1:0] ST_NOT_HELD = 3'b010;

    typedef struct packed {
        logic            command;
        logic [ID_W-1:0] client_id;
    } sawl_cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOTF_W-1:0]  slot_index;
        logic [ID_W-1:0]     handoff_id;
        logic [SLOTF_W-1:0]  handoff_slot;
        logic [QLEN_W-1:0]   queue_length;
    } sawl_rsp_t;

endpackage

`default_nettype wire

/* sv/sawl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sawl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* sv/slot_allocator_fifo_waitlist.sv */
// Slot allocator: owner ids per slot and a FIFO of waiting client ids.
//
// Usage: one command beat on cmd_* (request or release, with a client id)
// yields exactly one response beat on rsp_* (status, slot freed or granted,
// handoff of a slot to the former queue head, and the queue length after
// the command). Both channels use valid/stall; a beat moves on a rising
// clock edge with valid high and stall low.
// Owner ids and waiting ids live in two RAMs with registered
// reads, scanned one entry per cycle; a busy flag per slot marks which
// owner entries hold an id, so the lowest free slot is found at once.
// A request first scans the queue for its id when ids are waiting; a
// release scans the owner entries for its id, then hands the lowest free
// slot to the queue head when an id waits and a slot is free.
// Client id zero skips the scans.
// The response register frees the command side: a new command is taken
// while an earlier response still waits under rsp_stall; the response of
// that new command is held back until the waiting one is taken.
// Reset clears every busy flag (all slots free), the queue and the response
// valid; no clearing pass is needed and a command is taken right after.
`default_nettype none

module slot_allocator_fifo_waitlist
    import sawl_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cmd_valid,
    output logic           cmd_stall,
    input  wire sawl_cmd_t cmd_data,
    output logic           rsp_valid,
    input  wire logic      rsp_stall,
    output sawl_rsp_t      rsp_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_QSCAN,
        S_REQ,
        S_OSCAN,
        S_HAND,
        S_HAND_RD,
        S_DONE
    } state_t;

    state_t              state_reg;
    logic [ID_W-1:0]     id_reg;
    logic [SLOTS-1:0]    busy_reg;
    logic [QIDX_W-1:0]   head_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [SCAN_W-1:0]   issue_reg;
    logic                pend_reg;
    logic [SCAN_W-1:0]   pend_idx_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [ID_W-1:0]     hid_reg;
    logic [SLOT_W-1:0]   hslot_reg;
    logic                rsp_valid_reg;
    sawl_rsp_t           rsp_reg;

    logic                free_any;
    logic [SLOT_W-1:0]   free_idx;
    logic [QIDX_W-1:0]   tail_idx;
    logic [QIDX_W-1:0]   head_next;
    logic [QIDX_W-1:0]   q_raddr;
    logic [ID_W-1:0]     q_rdata;
    logic                q_we;
    logic [ID_W-1:0]     o_rdata;
    logic                o_we;
    logic [ID_W-1:0]     o_wdata;
    logic                q_issue;
    logic                o_issue;
    logic                q_hit;
    logic                q_last;
    logic                o_hit;
    logic                o_last;
    logic [SCAN_W-1:0]   pend_idx_inc;

    function automatic logic [QIDX_W-1:0] wrap_idx(input logic [QIDX_W:0] s);
        logic [QIDX_W:0] lim;
        lim = (QIDX_W + 1)'(WAITERS);
        if (s >= lim)
        begin
            return QIDX_W'(s - lim);
        end
        return QIDX_W'(s);
    endfunction

    // Lowest free slot: priority encode over the busy flags.
    always_comb
    begin
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!busy_reg[i])
            begin
                free_idx = SLOT_W'(i);
            end
        end
    end

    assign free_any  = ~&busy_reg;
    assign tail_idx  = wrap_idx((QIDX_W + 1)'(head_reg) + (QIDX_W + 1)'(count_reg));
    assign head_next = wrap_idx((QIDX_W + 1)'(head_reg) + (QIDX_W + 1)'(1));

    assign q_raddr = (state_reg == S_QSCAN)
                   ? wrap_idx((QIDX_W + 1)'(head_reg) + (QIDX_W + 1)'(issue_reg))
                   : head_reg;

    assign q_issue = issue_reg < SCAN_W'(count_reg);
    assign o_issue = issue_reg < SCAN_W'(SLOTS);

    assign pend_idx_inc = pend_idx_reg + SCAN_W'(1);
    assign q_hit  = pend_reg && (q_rdata == id_reg);
    assign q_last = pend_reg && (pend_idx_inc == SCAN_W'(count_reg));
    assign o_hit  = pend_reg && busy_reg[pend_idx_reg[SLOT_W-1:0]] && (o_rdata == id_reg);
    assign o_last = pend_reg && (pend_idx_inc == SCAN_W'(SLOTS));

    assign q_we    = (state_reg == S_REQ) && !free_any && (count_reg < CNT_W'(WAITERS));
    assign o_we    = ((state_reg == S_REQ) && free_any)
                  || (state_reg == S_HAND_RD);
    assign o_wdata = (state_reg == S_HAND_RD) ? q_rdata : id_reg;

    sawl_ram #(
        .WIDTH (ID_W),
        .DEPTH (WAITERS)
    ) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (tail_idx),
        .wdata (id_reg),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    sawl_ram #(
        .WIDTH (ID_W),
        .DEPTH (SLOTS)
    ) u_owner_ram (
        .clk   (clk),
        .we    (o_we),
        .waddr (free_idx),
        .wdata (o_wdata),
        .raddr (issue_reg[SLOT_W-1:0]),
        .rdata (o_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            busy_reg      <= '0;
            head_reg      <= '0;
            count_reg     <= '0;
            issue_reg     <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            // completion handles its own valid
            if (rsp_valid_reg && !rsp_stall && (state_reg != S_DONE))
            begin
                rsp_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        id_reg    <= cmd_data.client_id;
                        slot_reg  <= '0;
                        hid_reg   <= '0;
                        hslot_reg <= '0;
                        issue_reg <= '0;
                        pend_reg  <= 1'b0;
                        if (cmd_data.command == CMD_REQUEST)
                        begin
                            if (cmd_data.client_id == '0)
                            begin
                                // id zero is not a valid client: refuse it
                                status_reg <= ST_FULL;
                                state_reg  <= S_DONE;
                            end
                            else if (count_reg == '0)
                            begin
                                state_reg <= S_REQ;
                            end
                            else
                            begin
                                state_reg <= S_QSCAN;
                            end
                        end
                        else
                        begin
                            if (cmd_data.client_id == '0)
                            begin
                                status_reg <= ST_RELEASE | ST_NOT_HELD;
                                state_reg  <= S_HAND;
                            end
                            else
                            begin
                                status_reg <= ST_RELEASE;
                                state_reg  <= S_OSCAN;
                            end
                        end
                    end
                end

                S_QSCAN:
                begin
                    pend_reg     <= q_issue;
                    pend_idx_reg <= issue_reg;
                    if (q_issue)
                    begin
                        issue_reg <= issue_reg + SCAN_W'(1);
                    end
                    if (q_hit)
                    begin
                        status_reg <= ST_WAITING;
                        state_reg  <= S_DONE;
                    end
                    else if (q_last)
                    begin
                        state_reg <= S_REQ;
                    end
                end

                S_REQ:
                begin
                    if (free_any)
                    begin
                        busy_reg[free_idx] <= 1'b1;
                        slot_reg           <= free_idx;
                        status_reg         <= ST_GRANTED;
                    end
                    else if (count_reg < CNT_W'(WAITERS))
                    begin
                        count_reg  <= count_reg + CNT_W'(1);
                        status_reg <= ST_QUEUED;
                    end
                    else
                    begin
                        status_reg <= ST_FULL;
                    end
                    state_reg <= S_DONE;
                end

                S_OSCAN:
                begin
                    pend_reg     <= o_issue;
                    pend_idx_reg <= issue_reg;
                    if (o_issue)
                    begin
                        issue_reg <= issue_reg + SCAN_W'(1);
                    end
                    if (o_hit)
                    begin
                        busy_reg[pend_idx_reg[SLOT_W-1:0]] <= 1'b0;
                        slot_reg  <= pend_idx_reg[SLOT_W-1:0];
                        state_reg <= S_HAND;
                    end
                    else if (o_last)
                    begin
                        status_reg <= status_reg | ST_NOT_HELD;
                        state_reg  <= S_HAND;
                    end
                end

                S_HAND:
                begin
                    // queue head is read this cycle, used in the next
                    if ((count_reg != '0) && free_any)
                    begin
                        state_reg <= S_HAND_RD;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end

                S_HAND_RD:
                begin
                    hid_reg            <= q_rdata;
                    hslot_reg          <= free_idx;
                    busy_reg[free_idx] <= 1'b1;
                    head_reg           <= head_next;
                    count_reg          <= count_reg - CNT_W'(1);
                    status_reg         <= status_reg | ST_HANDOFF;
                    state_reg          <= S_DONE;
                end

                S_DONE:
                begin
                    // hold while an earlier beat still waits
                    if (!rsp_valid_reg || !rsp_stall)
                    begin
                        rsp_valid_reg        <= 1'b1;
                        rsp_reg.status       <= status_reg;
                        rsp_reg.slot_index   <= SLOTF_W'(slot_reg);
                        rsp_reg.handoff_id   <= hid_reg;
                        rsp_reg.handoff_slot <= SLOTF_W'(hslot_reg);
                        rsp_reg.queue_length <= QLEN_W'(count_reg);
                        state_reg            <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(WAITERS))
        else $error("wait count beyond queue depth");

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("response raised outside completion");

    a_handoff_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HAND_RD) |-> ((count_reg != '0) && free_any))
        else $error("handoff without waiter or free slot");

    a_handoff_id: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.status[2] && rsp_reg.status[0])
            |-> (rsp_reg.handoff_id != '0))
        else $error("handoff to id zero");

    a_grant_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_REQ) && free_any) |=> busy_reg[slot_reg])
        else $error("granted slot not marked busy");

endmodule

`default_nettype wire

/* verif/slot_grant_monitor.sv */
// Channel monitor for the slot allocator: predicts each response and compares it.
`timescale 1ns / 100ps

module slot_grant_monitor
    import sawl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    input  logic      cmd_stall,
    input  sawl_cmd_t cmd_data,
    input  logic      rsp_valid,
    input  logic      rsp_stall,
    input  sawl_rsp_t rsp_data,
    output int        errors,
    output int        pending
);

    logic [ID_W-1:0] owner [SLOTS];
    logic [ID_W-1:0] waitlist [$];
    sawl_rsp_t       awaited_outcomes [$];

    task automatic report_mismatch(input string field, input int got, input int want);
        if (errors < 100)
            $display("mismatch at %0t: %s got %0d want %0d", $realtime, field, got, want);
        errors++;
    endtask

    function automatic int lowest_slot_held_by(input logic [ID_W-1:0] id);
        for (int s = 0; s < SLOTS; s++)
            if (owner[s] == id)
                return s;
        return -1;
    endfunction

    // Update the shadow owners and wait list, return the response this beat yields.
    function automatic sawl_rsp_t apply_command(input sawl_cmd_t beat);
        sawl_rsp_t r;
        int        s;
        bit        queued_already;
        r = '0;
        queued_already = 1'b0;
        foreach (waitlist[i])
            if (waitlist[i] == beat.client_id)
                queued_already = 1'b1;
        if (beat.command == CMD_REQUEST)
        begin
            s = lowest_slot_held_by('0);
            if (beat.client_id == '0)
                r.status = ST_FULL;
            else if (queued_already)
                r.status = ST_WAITING;
            else if (s >= 0)
            begin
                owner[s] = beat.client_id;
                r.status = ST_GRANTED;
                r.slot_index = s[SLOTF_W-1:0];
            end
            else if (waitlist.size() < WAITERS)
            begin
                waitlist.push_back(beat.client_id);
                r.status = ST_QUEUED;
            end
            else
                r.status = ST_FULL;
        end
        else
        begin
            r.status = ST_RELEASE;
            s = (beat.client_id != '0) ? lowest_slot_held_by(beat.client_id) : -1;
            if (s >= 0)
            begin
                owner[s] = '0;
                r.slot_index = s[SLOTF_W-1:0];
            end
            else
                r.status |= ST_NOT_HELD;
            // hand the lowest free slot to the queue head
            s = lowest_slot_held_by('0);
            if (waitlist.size() > 0 && s >= 0)
            begin
                r.handoff_id = waitlist.pop_front();
                r.handoff_slot = s[SLOTF_W-1:0];
                owner[s] = r.handoff_id;
                r.status |= ST_HANDOFF;
            end
        end
        r.queue_length = QLEN_W'(waitlist.size());
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sawl_rsp_t want;
        if (!rst_n)
        begin
            foreach (owner[i])
                owner[i] = '0;
            waitlist.delete();
            awaited_outcomes.delete();
            errors = 0;
            pending <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (awaited_outcomes.size() == 0)
                    report_mismatch("unexpected response beat", int'(rsp_data), 0);
                else
                begin
                    want = awaited_outcomes.pop_front();
                    if (rsp_data.status != want.status)
                        report_mismatch("status", int'(rsp_data.status),
                                        int'(want.status));
                    if (rsp_data.slot_index != want.slot_index)
                        report_mismatch("slot_index", int'(rsp_data.slot_index),
                                        int'(want.slot_index));
                    if (rsp_data.handoff_id != want.handoff_id)
                        report_mismatch("handoff_id", int'(rsp_data.handoff_id),
                                        int'(want.handoff_id));
                    if (rsp_data.handoff_slot != want.handoff_slot)
                        report_mismatch("handoff_slot", int'(rsp_data.handoff_slot),
                                        int'(want.handoff_slot));
                    if (rsp_data.queue_length != want.queue_length)
                        report_mismatch("queue_length", int'(rsp_data.queue_length),
                                        int'(want.queue_length));
                end
            end
            if (cmd_valid && !cmd_stall)
                awaited_outcomes.push_back(apply_command(cmd_data));
            pending <= awaited_outcomes.size();
        end
    end

endmodule

/* verif/testbench.sv */
// Top of the slot allocator testbench: clock, reset, command traffic and verdict.
`timescale 1ns / 100ps

module testbench;
    import sawl_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int TAIL_CYCLES = 40;

    logic      clk;
    logic      rst_n = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_stall;
    sawl_cmd_t cmd_data = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    sawl_rsp_t rsp_data;

    int errors;
    int pending;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;

    slot_allocator_fifo_waitlist DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    slot_grant_monitor grant_monitor (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
        rsp_stall <= ($urandom_range(99) < recv_stall_pct);

    // Abort when no beat moves on either channel for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic drive_command(input logic op, input logic [ID_W-1:0] id);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_data.command <= op;
        cmd_data.client_id <= id;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
    endtask

    // Hold off the sender until every response has come back.
    task automatic drain_responses();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic random_traffic(input int count);
        int              req_pct;
        int              pick;
        logic [ID_W-1:0] id;
        for (int n = 0; n < count; n++)
        begin
            // alternate fill-heavy and release-heavy stretches
            req_pct = ((n / 60) % 2 == 0) ? 75 : 30;
            pick = $urandom_range(99);
            if (pick == 0)
                id = '0;
            else if (pick < 88)
                id = ID_W'($urandom_range(24, 1));
            else
                id = ID_W'($urandom_range(255, 1));
            drive_command(($urandom_range(99) < req_pct) ? CMD_REQUEST : CMD_RELEASE, id);
        end
    endtask

    initial
    begin
        send_idle_pct = 11;
        recv_stall_pct = 73;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        drive_command(CMD_REQUEST, 8'd255);
        drive_command(CMD_REQUEST, 8'd0);
        drive_command(CMD_RELEASE, 8'd0);
        drive_command(CMD_RELEASE, 8'd77);
        for (int id = 1; id < SLOTS; id++)
            drive_command(CMD_REQUEST, ID_W'(id));
        drive_command(CMD_REQUEST, 8'd128);
        drive_command(CMD_REQUEST, 8'd128);
        drive_command(CMD_REQUEST, 8'd0);
        drive_command(CMD_RELEASE, 8'd77);
        drive_command(CMD_RELEASE, 8'd255);
        drive_command(CMD_RELEASE, 8'd128);
        drive_command(CMD_RELEASE, 8'd15);
        drain_responses();

        random_traffic(300);
        drain_responses();

        send_idle_pct = 73;
        recv_stall_pct = 11;
        random_traffic(300);
        drain_responses();

        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_traffic(300);
        drain_responses();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
